// ===== hw/rtl/ebsd_pkg.sv =====
// Shared types and constants of the EUC byte stream decoder.
`timescale 1ns / 1ps

package ebsd_pkg;

    // Character geometry
    localparam int MAX_CHAR_BYTES     = 4;
    localparam int BITS_PER_BYTE_CODE = 7;
    localparam int CODE_W             = 28;
    localparam int POINT_W            = 30;
    localparam int LEN_W              = 3;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 3;

    // Special byte values
    localparam logic [7:0] LEAD_SS2 = 8'h8e;
    localparam logic [7:0] LEAD_SS3 = 8'h8f;
    localparam logic [7:0] C1_FIRST = 8'h80;
    localparam logic [7:0] C1_LAST  = 8'h9f;

    // Code set tags, bits 29:28 of the wide character
    localparam logic [1:0] TAG_SINGLE = 2'd0;
    localparam logic [1:0] TAG_CS2    = 2'd1;
    localparam logic [1:0] TAG_CS3    = 2'd2;
    localparam logic [1:0] TAG_CS1    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET1_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET2_TRAILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET3_TRAILING = 2'd2;

    // Configuration reset values
    localparam logic [2:0] SET1_TOTAL_RST    = 3'd2;
    localparam logic [1:0] SET2_TRAILING_RST = 2'd1;
    localparam logic [1:0] SET3_TRAILING_RST = 2'd2;

    // What a byte means when no character is in progress
    localparam logic [1:0] LEAD_SINGLE  = 2'd0;
    localparam logic [1:0] LEAD_START   = 2'd1;
    localparam logic [1:0] LEAD_ILLEGAL = 2'd2;

    // Classified beat passed from front to back
    typedef struct packed {
        logic             restart;
        logic [7:0]       data_byte;
        logic             trail_ok;       // legal as a trailing byte
        logic [1:0]       lead_kind;
        logic [1:0]       lead_tag;
        logic [LEN_W-1:0] lead_remaining; // trailing bytes after the lead
        logic [LEN_W-1:0] single_len;
    } ebsd_entry_t;

    // One result beat
    typedef struct packed {
        logic               status;
        logic [POINT_W-1:0] code_point;
        logic [LEN_W-1:0]   byte_length;
    } ebsd_result_t;

endpackage

// ===== hw/rtl/ebsd_if.sv =====
// Valid/ready channel interfaces for input bytes and decoded characters.
`timescale 1ns / 1ps

interface ebsd_byte_if;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [7:0] data_byte;

    modport source (output valid, output restart, output data_byte, input ready);
    modport sink (input valid, input restart, input data_byte, output ready);
endinterface

interface ebsd_char_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [29:0] code_point;
    logic [2:0]  byte_length;

    modport source (output valid, output status, output code_point, output byte_length,
                    input ready);
    modport sink (input valid, input status, input code_point, input byte_length,
                  output ready);
endinterface

// ===== hw/rtl/euc_byte_stream_decoder.sv =====
// Top level of the EUC byte stream decoder.
`timescale 1ns / 1ps

// Decodes an EUC byte stream into wide characters. One byte beat is accepted
// per cycle and at most one character beat comes out for it: ASCII and C1
// bytes come out as themselves, multibyte characters come out when their
// last byte arrives, tagged with their code set in bits 29:28, and an
// illegal sequence gives status 1 with zero code and length. A byte with
// restart set drops any partial character and gives no result. The front
// end classifies each byte and writes it into a FIFO_DEPTH-entry queue; the
// back end pops one entry per cycle while the output register is free or
// being drained, and a result passes a queue slot and then the output register.
// Sustained rate is one byte per cycle as long as the output side takes beats;
// input ready drops only when the queue fills. Configuration is written
// through cfg_we/cfg_index/cfg_wdata while no beats are in flight.
module euc_byte_stream_decoder
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    ebsd_byte_if.sink                           byte_ch,
    ebsd_char_if.source                         char_ch,
    input  logic                                cfg_we,
    input  logic [ebsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ebsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ebsd_pkg::ebsd_entry_t  front_entry;
    ebsd_pkg::ebsd_entry_t  head_entry;
    ebsd_pkg::ebsd_result_t result;
    logic                   queue_full;
    logic                   head_valid;
    logic                   pop;
    logic                   push;

    assign byte_ch.ready = !queue_full;
    assign push          = byte_ch.valid && !queue_full;

    ebsd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .restart   (byte_ch.restart),
        .data_byte (byte_ch.data_byte),
        .entry     (front_entry)
    );

    ebsd_queue #(.DEPTH(FIFO_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ebsd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_ready  (char_ch.ready),
        .out_valid  (char_ch.valid),
        .out_result (result)
    );

    assign char_ch.status      = result.status;
    assign char_ch.code_point  = result.code_point;
    assign char_ch.byte_length = result.byte_length;

endmodule

// ===== hw/rtl/ebsd_front.sv =====
// Front end: configuration registers and classification of incoming bytes.
`timescale 1ns / 1ps

module ebsd_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ebsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ebsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                restart,
    input  logic [7:0]                          data_byte,
    output ebsd_pkg::ebsd_entry_t               entry
);

    localparam logic [ebsd_pkg::LEN_W-1:0] MAX_TOTAL =
        ebsd_pkg::LEN_W'(ebsd_pkg::MAX_CHAR_BYTES);
    localparam logic [ebsd_pkg::LEN_W-1:0] MAX_TRAIL =
        ebsd_pkg::LEN_W'(ebsd_pkg::MAX_CHAR_BYTES - 1);

    logic [2:0] set1_total_reg;
    logic [1:0] set2_trailing_reg;
    logic [1:0] set3_trailing_reg;

    logic [ebsd_pkg::LEN_W-1:0] set1_clamped;
    logic [ebsd_pkg::LEN_W-1:0] set2_clamped;
    logic [ebsd_pkg::LEN_W-1:0] set3_clamped;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set1_total_reg    <= ebsd_pkg::SET1_TOTAL_RST;
            set2_trailing_reg <= ebsd_pkg::SET2_TRAILING_RST;
            set3_trailing_reg <= ebsd_pkg::SET3_TRAILING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ebsd_pkg::CFG_SET1_TOTAL:    set1_total_reg    <= cfg_wdata;
                ebsd_pkg::CFG_SET2_TRAILING: set2_trailing_reg <= cfg_wdata[1:0];
                ebsd_pkg::CFG_SET3_TRAILING: set3_trailing_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Lengths saturate at the longest character
    assign set1_clamped = (set1_total_reg > MAX_TOTAL) ? MAX_TOTAL : set1_total_reg;
    assign set2_clamped = ({1'b0, set2_trailing_reg} > MAX_TRAIL) ? MAX_TRAIL
                                                                  : {1'b0, set2_trailing_reg};
    assign set3_clamped = ({1'b0, set3_trailing_reg} > MAX_TRAIL) ? MAX_TRAIL
                                                                  : {1'b0, set3_trailing_reg};

    // Classify the byte as a lead; back end picks trail_ok when mid-character
    always_comb
    begin
        entry                = '0;
        entry.restart        = restart;
        entry.data_byte      = data_byte;
        entry.trail_ok       = (data_byte > ebsd_pkg::C1_LAST);
        entry.lead_kind      = ebsd_pkg::LEAD_SINGLE;
        entry.lead_tag       = ebsd_pkg::TAG_SINGLE;
        entry.lead_remaining = '0;
        entry.single_len     = ebsd_pkg::LEN_W'(1);
        if (data_byte < ebsd_pkg::C1_FIRST)
        begin
            // ASCII; NUL has length zero
            entry.single_len = (data_byte != 8'd0) ? ebsd_pkg::LEN_W'(1) : '0;
        end
        else if (data_byte == ebsd_pkg::LEAD_SS2 && set2_trailing_reg != 2'd0)
        begin
            entry.lead_kind      = ebsd_pkg::LEAD_START;
            entry.lead_tag       = ebsd_pkg::TAG_CS2;
            entry.lead_remaining = set2_clamped;
        end
        else if (data_byte == ebsd_pkg::LEAD_SS3 && set3_trailing_reg != 2'd0)
        begin
            entry.lead_kind      = ebsd_pkg::LEAD_START;
            entry.lead_tag       = ebsd_pkg::TAG_CS3;
            entry.lead_remaining = set3_clamped;
        end
        else if (data_byte <= ebsd_pkg::C1_LAST)
        begin
            // C1 control, also a disabled single shift
            entry.single_len = ebsd_pkg::LEN_W'(1);
        end
        else if (set1_total_reg == 3'd0)
        begin
            entry.lead_kind = ebsd_pkg::LEAD_ILLEGAL;
        end
        else
        begin
            entry.lead_kind      = ebsd_pkg::LEAD_START;
            entry.lead_tag       = ebsd_pkg::TAG_CS1;
            entry.lead_remaining = set1_clamped - ebsd_pkg::LEN_W'(1);
        end
    end

endmodule

// ===== hw/rtl/ebsd_queue.sv =====
// Small FIFO of classified beats between front and back end.
`timescale 1ns / 1ps

module ebsd_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ebsd_pkg::ebsd_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output ebsd_pkg::ebsd_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ebsd_pkg::ebsd_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ebsd_back.sv =====
// Back end: multibyte character state and the output register.
`timescale 1ns / 1ps

module ebsd_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  ebsd_pkg::ebsd_entry_t               head_entry,
    output logic                                pop,
    input  logic                                out_ready,
    output logic                                out_valid,
    output ebsd_pkg::ebsd_result_t              out_result
);

    localparam int CW = ebsd_pkg::CODE_W;
    localparam int BW = ebsd_pkg::BITS_PER_BYTE_CODE;
    localparam int LW = ebsd_pkg::LEN_W;

    logic [LW-1:0] remaining_reg, remaining_next;
    logic [CW-1:0] code_reg, code_next;
    logic [1:0]    tag_reg, tag_next;
    logic [LW-1:0] taken_reg, taken_next;

    logic                   out_valid_reg;
    ebsd_pkg::ebsd_result_t out_result_reg;

    logic                   emit;
    ebsd_pkg::ebsd_result_t result;
    logic [CW-1:0]          code_acc;
    logic [CW-1:0]          code_init;
    logic [LW-1:0]          taken_inc;

    // Take a beat whenever the output register is free or being drained
    assign pop = head_valid && (!out_valid_reg || out_ready);

    assign code_acc  = CW'({code_reg, head_entry.data_byte[BW-1:0]});
    assign code_init = (head_entry.lead_tag == ebsd_pkg::TAG_CS1)
                       ? CW'(head_entry.data_byte[BW-1:0]) : '0;
    assign taken_inc = taken_reg + LW'(1);

    // Character state update
    always_comb
    begin
        remaining_next = remaining_reg;
        code_next      = code_reg;
        tag_next       = tag_reg;
        taken_next     = taken_reg;
        emit           = 1'b0;
        result         = '0;
        if (pop)
        begin
            if (head_entry.restart)
            begin
                remaining_next = '0;
                code_next      = '0;
                tag_next       = ebsd_pkg::TAG_SINGLE;
                taken_next     = '0;
            end
            else if (remaining_reg != '0)
            begin
                remaining_next = '0;
                code_next      = '0;
                tag_next       = ebsd_pkg::TAG_SINGLE;
                taken_next     = '0;
                emit           = 1'b1;
                if (!head_entry.trail_ok)
                begin
                    // bad trailing byte is consumed
                    result.status = 1'b1;
                end
                else if (remaining_reg == LW'(1))
                begin
                    result.code_point  = {tag_reg, code_acc};
                    result.byte_length = taken_inc;
                end
                else
                begin
                    emit           = 1'b0;
                    remaining_next = remaining_reg - LW'(1);
                    code_next      = code_acc;
                    tag_next       = tag_reg;
                    taken_next     = taken_inc;
                end
            end
            else
            begin
                unique case (head_entry.lead_kind)
                    ebsd_pkg::LEAD_SINGLE:
                    begin
                        emit               = 1'b1;
                        result.code_point  = ebsd_pkg::POINT_W'(head_entry.data_byte);
                        result.byte_length = head_entry.single_len;
                    end
                    ebsd_pkg::LEAD_START:
                    begin
                        if (head_entry.lead_remaining == '0)
                        begin
                            // one-byte code set 1 completes on its lead
                            emit               = 1'b1;
                            result.code_point  = {head_entry.lead_tag, code_init};
                            result.byte_length = LW'(1);
                        end
                        else
                        begin
                            remaining_next = head_entry.lead_remaining;
                            code_next      = code_init;
                            tag_next       = head_entry.lead_tag;
                            taken_next     = LW'(1);
                        end
                    end
                    ebsd_pkg::LEAD_ILLEGAL:
                    begin
                        emit          = 1'b1;
                        result.status = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            code_reg      <= '0;
            tag_reg       <= ebsd_pkg::TAG_SINGLE;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            code_reg      <= code_next;
            tag_reg       <= tag_next;
            taken_reg     <= taken_next;
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ===== hw/rtl/ebsd_checker.sv =====
// Port-level assertions for the EUC byte stream decoder, bound to the top level.
`timescale 1ns / 1ps

module ebsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_status,
    input logic [29:0] out_code_point,
    input logic [2:0]  out_byte_length
);

    // A pending result beat is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // Illegal sequences carry no code and no length
    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> (out_code_point == 30'd0) && (out_byte_length == 3'd0))
        else $error("illegal result carries code or length");

    // Untagged characters are one byte, or zero for NUL
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_status && (out_code_point[29:28] == 2'd0)
        |-> (out_byte_length == {2'b00, (out_code_point != 30'd0)}))
        else $error("single-byte character has wrong length");

    // Tagged characters are at least one byte long
    a_tagged_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_status && (out_code_point[29:28] != 2'd0)
        |-> (out_byte_length != 3'd0))
        else $error("multibyte character reports zero length");

endmodule

bind euc_byte_stream_decoder ebsd_checker u_ebsd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (char_ch.valid),
    .out_ready       (char_ch.ready),
    .out_status      (char_ch.status),
    .out_code_point  (char_ch.code_point),
    .out_byte_length (char_ch.byte_length)
);
